/* hw/rtl/srrw_pkg.sv */
// Shared types and constants for the selective-repeat receive window.
package srrw_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned WSIZE_W  = 5;
  localparam int unsigned SLOT_W   = TAG_W + LEN_W;

  localparam int unsigned WINDOW_MAX_DEF = 16;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(16);

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 3'd0,
    ACT_DATA    = 3'd1,
    ACT_END     = 3'd2,
    ACT_REFUSE  = 3'd3,
    ACT_UNKNOWN = 3'd4
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_END     = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SLOT,
    S_CLOSE,
    S_READ,
    S_DELIV,
    S_ACK
  } state_e;

endpackage

/* hw/rtl/srrw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module srrw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/selective_repeat_receive_window_core.sv */
// Top level of the selective-repeat ARQ receive window.
//
// Input channel (in_valid_i / in_ready_o) takes one packet event per word:
// start, data, end, refuse or unknown, with its sequence number, corruption
// flag and payload descriptor. Output channel (out_valid_o / out_ready_i)
// returns result words: in-order deliveries, acks, ended and refused.
// last_o marks the final word caused by one input word.
// cfg_we_i / cfg_wdata_i write the window size; write it only while idle.
//
// One word is worked on at a time; in_ready_o is high only when the
// sequencer is idle. Each delivery of a buffered packet is a RAM read,
// then an output load. The offset, the head-plus-offset slot sum and the
// base step run through one shared 16-bit adder stepped by the sequencer.
//
// Reset clears the base, the ring head, all slot valid bits and the
// transfer-closed flag, and sets the window size to 16. The slot RAM holds
// no reset state; only slots with a set valid bit are read. When the
// receiver stalls, the result waits in the output register and the
// sequencer holds in its current state until the register frees up.
module selective_repeat_receive_window_core #(
  parameter int unsigned WindowMax = srrw_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srrw_pkg::WSIZE_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [srrw_pkg::ACTION_W-1:0] action_i,
  input  logic [srrw_pkg::SEQ_W-1:0]   seq_num_i,
  input  logic                         corrupted_i,
  input  logic [srrw_pkg::TAG_W-1:0]   payload_tag_i,
  input  logic [srrw_pkg::LEN_W-1:0]   payload_len_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srrw_pkg::KIND_W-1:0]  kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]   out_seq_o,
  output logic [srrw_pkg::TAG_W-1:0]   out_tag_o,
  output logic [srrw_pkg::LEN_W-1:0]   out_len_o,
  output logic                         last_o
);
  import srrw_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowMax);

  // Sequencer and window state
  state_e                state_q, state_d;
  logic [SEQ_W-1:0]      base_q, base_d;
  logic [IdxW-1:0]       head_q, head_d;
  logic [WindowMax-1:0]  valid_q, valid_d;
  logic                  done_q, done_d;
  logic [IdxW:0]         off_q, off_d;
  logic [WSIZE_W-1:0]    wsize_q;

  // Captured input word
  logic [ACTION_W-1:0]   act_q;
  logic [SEQ_W-1:0]      seq_q;
  logic                  corrupt_q;
  logic [TAG_W-1:0]      tag_q;
  logic [LEN_W-1:0]      len_q;

  // Output register
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [SEQ_W-1:0]      oseq_q;
  logic [TAG_W-1:0]      otag_q;
  logic [LEN_W-1:0]      olen_q;
  logic                  last_q;

  logic                  ld_out;
  kind_e                 o_kind;
  logic [SEQ_W-1:0]      o_seq;
  logic [TAG_W-1:0]      o_tag;
  logic [LEN_W-1:0]      o_len;
  logic                  o_last;
  logic                  can_load;

  // Shared adder
  logic [SEQ_W-1:0]      alu_a, alu_b, alu_sum;
  logic                  alu_ci;

  logic [SEQ_W:0]        eff_win;
  logic                  in_window;
  logic [IdxW:0]         slot_wide;
  logic [IdxW-1:0]       slot;
  logic [IdxW-1:0]       head_next;

  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_rdata;

  assign alu_sum = alu_a + alu_b + {{(SEQ_W-1){1'b0}}, alu_ci};

  // Clamp the window size: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (wsize_q == '0) begin
      eff_win = (SEQ_W+1)'(1);
    end else if (int'(wsize_q) > int'(WindowMax)) begin
      eff_win = (SEQ_W+1)'(WindowMax);
    end else begin
      eff_win = (SEQ_W+1)'(wsize_q);
    end
  end

  assign in_window = {1'b0, alu_sum} < eff_win;

  // head + offset stays below twice the ring size: one compare and subtract.
  assign slot_wide = alu_sum[IdxW:0];
  assign slot = (slot_wide >= (IdxW+1)'(WindowMax))
              ? IdxW'(slot_wide - (IdxW+1)'(WindowMax))
              : IdxW'(slot_wide);

  assign head_next = (head_q == IdxW'(WindowMax - 1)) ? '0 : head_q + 1'b1;

  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    head_d  = head_q;
    valid_d = valid_q;
    done_d  = done_q;
    off_d   = off_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    ld_out  = 1'b0;
    o_kind  = KIND_ACK;
    o_seq   = '0;
    o_tag   = '0;
    o_len   = '0;
    o_last  = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    alu_ci  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // offset = seq - base
        alu_a   = seq_q;
        alu_b   = ~base_q;
        alu_ci  = 1'b1;
        state_d = S_IDLE;
        if (!corrupt_q) begin
          unique case (act_q) inside
            ACT_START: begin
              base_d  = '0;
              head_d  = '0;
              valid_d = '0;
              done_d  = 1'b0;
            end
            ACT_DATA: begin
              if (!done_q && in_window) begin
                off_d   = alu_sum[IdxW:0];
                state_d = S_SLOT;
              end
            end
            ACT_END, ACT_REFUSE: begin
              if (!done_q) begin
                state_d = S_CLOSE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        alu_a = SEQ_W'(head_q);
        alu_b = SEQ_W'(off_q);
        if (valid_q[slot]) begin
          state_d = S_ACK;
        end else begin
          ram_we        = 1'b1;
          valid_d[slot] = 1'b1;
          state_d       = S_READ;
        end
      end
      S_CLOSE: begin
        if (can_load) begin
          ld_out  = 1'b1;
          o_kind  = (act_q == ACT_END) ? KIND_END : KIND_REFUSED;
          o_last  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (valid_q[head_q]) begin
          ram_re  = 1'b1;
          state_d = S_DELIV;
        end else begin
          state_d = S_ACK;
        end
      end
      S_DELIV: begin
        alu_a = base_q;
        alu_b = SEQ_W'(1);
        if (can_load) begin
          ld_out          = 1'b1;
          o_kind          = KIND_DELIVER;
          o_seq           = base_q;
          o_tag           = ram_rdata[SLOT_W-1:LEN_W];
          o_len           = ram_rdata[LEN_W-1:0];
          valid_d[head_q] = 1'b0;
          head_d          = head_next;
          base_d          = alu_sum;
          state_d         = S_READ;
        end
      end
      S_ACK: begin
        if (can_load) begin
          ld_out  = 1'b1;
          o_kind  = KIND_ACK;
          o_seq   = seq_q;
          o_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      done_q      <= 1'b0;
      off_q       <= '0;
      wsize_q     <= WSIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      head_q  <= head_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      off_q   <= off_d;
      if (cfg_we_i) begin
        wsize_q <= cfg_wdata_i;
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, load on result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q     <= action_i;
      seq_q     <= seq_num_i;
      corrupt_q <= corrupted_i;
      tag_q     <= payload_tag_i;
      len_q     <= payload_len_i;
    end
    if (ld_out) begin
      kind_q <= o_kind;
      oseq_q <= o_seq;
      otag_q <= o_tag;
      olen_q <= o_len;
      last_q <= o_last;
    end
  end

  srrw_ram #(
    .Width(SLOT_W),
    .Depth(WindowMax)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot),
    .wdata_i({tag_q, len_q}),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_seq_o   = oseq_q;
  assign out_tag_o   = otag_q;
  assign out_len_o   = olen_q;
  assign last_o      = last_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the selective-repeat receive window core.
module tb;
  import srrw_pkg::*;

  localparam int unsigned WIN             = WINDOW_MAX_DEF;
  localparam int unsigned SETTLE_CYCLES   = 64;    // margin for the longest drain of a full window
  localparam int unsigned QUIET_LIMIT     = 2000;  // cycles with no word moved on either side
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned WORDS_PER_PHASE = 6;
  localparam int unsigned PRESSURE_PHASE  = 2;
  localparam int unsigned DRAIN_PHASE     = 4;

  // One packet event as offered on the input channel. The action stays a raw
  // vector so that the unknown codes above ACT_UNKNOWN can be sent too.
  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [SEQ_W-1:0]    seq;
    logic                corrupted;
    logic [TAG_W-1:0]    tag;
    logic [LEN_W-1:0]    len;
  } arq_word_t;

  typedef struct {
    kind_e            kind;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_word_t;

  // Tracks the receive window (base, ring head, buffered slots, closed flag)
  // and queues the result words that each accepted packet event must produce.
  class arq_window_tracker;
    logic [WSIZE_W-1:0] wsize;
    logic [SEQ_W-1:0]   base;
    int unsigned        head;
    bit                 held [WIN];
    logic [TAG_W-1:0]   held_tag [WIN];
    logic [LEN_W-1:0]   held_len [WIN];
    bit                 closed;
    result_word_t       expected_results [$];
    int unsigned        errors;
    int unsigned        results_checked;
    int unsigned        words_noted;
    int unsigned        effective_words;
    int unsigned        longest_drain;

    function new();
      wsize  = WSIZE_RESET;
      closed = 1'b0;
      clear_window();
    endfunction

    function void clear_window();
      base = '0;
      head = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void set_window(logic [WSIZE_W-1:0] value);
      wsize = value;
    endfunction

    // Zero acts as one, anything past the slot count acts as the slot count.
    function int unsigned live_span();
      if (wsize == 0) return 1;
      if (wsize > WIN) return WIN;
      return wsize;
    endfunction

    function void expect_word(kind_e kind, logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag,
                              logic [LEN_W-1:0] len, logic last);
      result_word_t r;
      r.kind = kind;
      r.seq  = seq;
      r.tag  = tag;
      r.len  = len;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function void note_word(arq_word_t w);
      logic [SEQ_W-1:0] off;
      int unsigned      slot;
      int unsigned      drained;
      words_noted++;
      if (w.corrupted) return;
      if (w.action == ACT_START) begin
        clear_window();
        closed = 1'b0;
        effective_words++;
        return;
      end
      if (w.action > ACT_REFUSE || closed) return;
      if (w.action == ACT_END || w.action == ACT_REFUSE) begin
        closed = 1'b1;
        expect_word(w.action == ACT_END ? KIND_END : KIND_REFUSED, '0, '0, '0, 1'b1);
        effective_words++;
        return;
      end
      off = w.seq - base;
      if (off >= live_span()) return;
      effective_words++;
      slot = (head + off) % WIN;
      if (held[slot]) begin
        expect_word(KIND_ACK, w.seq, '0, '0, 1'b1);
        return;
      end
      held[slot]     = 1'b1;
      held_tag[slot] = w.tag;
      held_len[slot] = w.len;
      drained = 0;
      while (held[head]) begin
        expect_word(KIND_DELIVER, base, held_tag[head], held_len[head], 1'b0);
        held[head] = 1'b0;
        head       = (head + 1) % WIN;
        base       = base + 1'b1;
        drained++;
      end
      if (drained > longest_drain) longest_drain = drained;
      expect_word(KIND_ACK, w.seq, '0, '0, 1'b1);
    endfunction

    function void compare_field(string name, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                             logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len, logic last);
      result_word_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d seq %0h tag %0h len %0h last %0b",
               kind, seq, tag, len, last);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("out_seq", want.seq, seq);
      compare_field("out_tag", want.tag, tag);
      compare_field("out_len", want.len, len);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [WSIZE_W-1:0]  cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i      = '0;
  logic [SEQ_W-1:0]    seq_num_i     = '0;
  logic                corrupted_i   = 1'b0;
  logic [TAG_W-1:0]    payload_tag_i = '0;
  logic [LEN_W-1:0]    payload_len_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [KIND_W-1:0]   kind_o;
  logic [SEQ_W-1:0]    out_seq_o;
  logic [TAG_W-1:0]    out_tag_o;
  logic [LEN_W-1:0]    out_len_o;
  logic                last_o;

  arq_window_tracker tracker = new();
  int unsigned       rx_hold_reqs = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       window_writes = 0;

  selective_repeat_receive_window_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .seq_num_i     (seq_num_i),
    .corrupted_i   (corrupted_i),
    .payload_tag_i (payload_tag_i),
    .payload_len_i (payload_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .out_seq_o     (out_seq_o),
    .out_tag_o     (out_tag_o),
    .out_len_o     (out_len_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Check every result word taken at an edge. Outputs and ready are read in
  // the active region, so they still hold their values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_word(kind_o, out_seq_o, out_tag_o, out_len_o, last_o);
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles, %0d results still expected",
             quiet_cycles, tracker.expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: cycle through stall patterns of its own, from no stalls at all
  // to heavy random stalls. On request, hold off for a long stretch so the
  // output register fills and the core has to stall its input.
  initial begin : rx_side
    int unsigned tick;
    int unsigned holds_done;
    tick = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (rx_hold_reqs != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      case ((tick / 97) % 4)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready_i <= (tick % 5) < 3;
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 9) != 0);
        end
      endcase
    end
  end

  // Offer one word and hold it until the core takes it, then log it with the
  // tracker. Returns at the accepting edge so the next word can follow at once.
  task automatic send_word(input arq_word_t w);
    in_valid_i    <= 1'b1;
    action_i      <= w.action;
    seq_num_i     <= w.seq;
    corrupted_i   <= w.corrupted;
    payload_tag_i <= w.tag;
    payload_len_i <= w.len;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(w);
  endtask

  task automatic pause_input(input int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding result word to come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_results.size() != 0);
  endtask

  // Also let a word that causes no result finish inside the core.
  task automatic wait_drained();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WSIZE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_window(value);
    window_writes++;
  endtask

  function automatic arq_word_t data_word(logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag,
                                          logic [LEN_W-1:0] len);
    arq_word_t w;
    w.action    = ACT_DATA;
    w.seq       = seq;
    w.corrupted = 1'b0;
    w.tag       = tag;
    w.len       = len;
    return w;
  endfunction

  function automatic arq_word_t ctrl_word(logic [ACTION_W-1:0] action);
    arq_word_t w;
    w           = data_word(SEQ_W'($urandom), $urandom, LEN_W'($urandom));
    w.action    = action;
    return w;
  endfunction

  // Mostly data inside the current window with random payload, biased toward
  // the base so buffered runs drain; the rest is out-of-window and wrapped
  // numbers, corrupted words, unknown codes and transfer open/close events.
  function automatic arq_word_t random_word();
    arq_word_t   w;
    int unsigned pick;
    int unsigned reach;
    reach       = tracker.live_span();
    pick        = $urandom_range(0, 99);
    w           = data_word(tracker.base, $urandom, LEN_W'($urandom));
    w.corrupted = ($urandom_range(0, 19) == 0);
    if (tracker.closed && $urandom_range(0, 3) != 0) begin
      w.action = ACT_START;
    end else if (pick < 30) begin
      w.seq = tracker.base;
    end else if (pick < 75) begin
      w.seq = tracker.base + SEQ_W'($urandom_range(0, reach - 1));
    end else if (pick < 83) begin
      w.seq = SEQ_W'($urandom);
    end else if (pick < 88) begin
      w.seq = tracker.base + SEQ_W'(reach + $urandom_range(0, 3));
    end else if (pick < 91) begin
      w.seq = tracker.base - SEQ_W'($urandom_range(1, 4));
    end else if (pick < 94) begin
      w.action = ACT_UNKNOWN + ACTION_W'($urandom_range(0, 3));
    end else if (pick < 96) begin
      w.action = ACT_START;
    end else if (pick < 98) begin
      w.action = ACT_END;
    end else begin
      w.action = ACT_REFUSE;
    end
    return w;
  endfunction

  initial begin : stimulus
    arq_word_t          w;
    logic [WSIZE_W-1:0] window_plan [NUM_PHASES];
    int unsigned        phase_base;
    int unsigned        burst;
    bit                 mid_drain_done;

    window_plan = '{5'd31, 5'd0, 5'd1, 5'd17, 5'd4, WSIZE_W'($urandom_range(2, 15)), 5'd16};
    mid_drain_done = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, window at its reset size of 16, base at zero.
    // Deliver seq 0 with all-ones payload; base moves to 1.
    send_word(data_word(16'h0000, 32'hFFFF_FFFF, 11'h7FF));
    // Drop a corrupted word that would otherwise deliver.
    w = data_word(16'h0001, '0, '0);
    w.corrupted = 1'b1;
    send_word(w);
    // Ignore unknown action codes, lowest and highest.
    send_word(ctrl_word(ACT_UNKNOWN));
    send_word(ctrl_word(ACT_UNKNOWN + ACTION_W'(3)));
    // Drop data just behind the base (wraps to a huge offset) and one past the window.
    send_word(data_word(16'hFFFF, $urandom, LEN_W'($urandom)));
    send_word(data_word(16'd17, $urandom, LEN_W'($urandom)));
    // Fill the window from its far edge down; each earns only an ack.
    for (int s = 16; s >= 2; s--) begin
      send_word(data_word(SEQ_W'(s), $urandom, LEN_W'($urandom)));
    end
    // Duplicate of a buffered packet: fresh ack, nothing stored.
    send_word(data_word(16'd9, $urandom, LEN_W'($urandom)));
    // Fill the hole at the base: drain all sixteen slots, then ack.
    send_word(data_word(16'd1, 32'h0000_0000, 11'h000));
    // Close the transfer; data while closed is ignored. Reopen, refuse, reopen.
    send_word(ctrl_word(ACT_END));
    send_word(data_word(16'd17, $urandom, LEN_W'($urandom)));
    send_word(ctrl_word(ACT_START));
    send_word(ctrl_word(ACT_REFUSE));
    send_word(ctrl_word(ACT_START));

    // Random phases, one window setting each, written only while idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_window(window_plan[p]);
      if ($urandom_range(0, 1) != 0 || tracker.closed) begin
        send_word(ctrl_word(ACT_START));
      end
      if (p == PRESSURE_PHASE) begin
        // Hold the receiver off and keep offering back to back.
        rx_hold_reqs++;
        repeat (12) send_word(random_word());
      end
      phase_base = tracker.effective_words;
      while (tracker.effective_words - phase_base < WORDS_PER_PHASE) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_word(random_word());
        if (p == DRAIN_PHASE && !mid_drain_done) begin
          hold_until_drained();
          mid_drain_done = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          pause_input($urandom_range(20, 40));
        end else begin
          pause_input($urandom_range(0, 4));
        end
      end
    end

    wait_drained();
    if (tracker.expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", tracker.expected_results.size());
    end
    $display("covered %0d packet events (%0d with effect) and %0d result words",
             tracker.words_noted, tracker.effective_words, tracker.results_checked);
    $display("window sizes written: %0d, longest in-order drain: %0d packets",
             window_writes, tracker.longest_drain);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
